### design/ps2kfr_pkg.sv
// Shared types and constants for the PS/2 keyboard frame receiver.
// No dependencies; imported by ps2kfr_frame_rx and ps2_keyboard_frame_receiver.
`default_nettype none

package ps2kfr_pkg;

	typedef enum logic [1:0] {
		OP_FALL = 2'd0,
		OP_RISE = 2'd1,
		OP_TICK = 2'd2,
		OP_READ = 2'd3
	} op_t;

	localparam logic [7:0] TIMEOUT_RESET = 8'd20;
	localparam logic [7:0] DATA_MSB      = 8'h80;
	localparam logic [7:0] GAP_MAX       = 8'hFF;
	localparam logic [3:0] POS_IDLE      = 4'd0;
	localparam logic [3:0] POS_PARITY    = 4'(1 + 8);
	localparam logic [3:0] POS_STOP      = 4'(1 + 8 + 1);

	typedef struct packed {
		logic       done;
		logic       error;
		logic       sync_lost;
		logic       failure;
		logic [7:0] data;
	} frame_evt_t;

endpackage

`default_nettype wire

### design/ps2_keyboard_frame_receiver.sv
// Top level: PS/2 keyboard frame receiver with a scancode ring buffer held in a synchronous memory.
// Depends on ps2kfr_pkg and ps2kfr_frame_rx.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+--------------------------------------------------
//   input    | in_valid / in_stall      | op, data_bit
//   result   | out_valid / out_stall    | read_valid, read_byte, frame_done, frame_error,
//            |                          | sync_lost, failure_seen, unread_level
//   config   | cfg_valid / cfg_ready    | cfg_data (gap_timeout_ticks)
//
// One item per cycle while the input is not stalled; each result appears in the cycle after its item is accepted.
// The scancode memory is read and written on the edge that accepts the item, with its read data
// registered, so a read right after a store sees the byte.
// The input stalls only while a result is held and the result side stalls.
// Reset is asynchronous and needs no clearing pass; the memory contents are not reset.
`default_nettype none

module ps2_keyboard_frame_receiver #(
	parameter int BUF_DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] op,
	input  wire logic       data_bit,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            read_valid,
	output logic [7:0]      read_byte,
	output logic            frame_done,
	output logic            frame_error,
	output logic            sync_lost,
	output logic            failure_seen,
	output logic [3:0]      unread_level,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);
	import ps2kfr_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(BUF_DEPTH - 1);
	localparam logic [AW-1:0] DEPTH_MOD = AW'(BUF_DEPTH);

	logic [7:0]    mem [BUF_DEPTH];
	logic          accept;
	op_t           op_in;
	frame_evt_t    evt;
	logic [AW-1:0] slot_q, slot_d;
	logic [AW-1:0] count_q, count_d;
	logic [AW-1:0] rd_idx;
	logic          rd_en;
	logic          wr_en;

	logic          out_valid_q;
	logic          read_valid_s1;
	logic [7:0]    rdata_s1;
	logic          done_s1;
	logic          error_s1;
	logic          sync_lost_s1;
	logic          failure_s1;
	logic [3:0]    level_s1;

	assign op_in     = op_t'(op);
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	ps2kfr_frame_rx u_frame_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.op       (op_in),
		.data_bit (data_bit),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.evt      (evt)
	);

	always_comb begin
		slot_d  = slot_q;
		count_d = count_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		rd_idx  = slot_q - count_d;
		if (op_in == OP_FALL && evt.done) begin
			wr_en  = 1'b1;
			slot_d = (slot_q == LAST) ? '0 : slot_q + AW'(1);
			if (count_q < LAST) begin
				count_d = count_q + AW'(1);
			end
		end else if (op_in == OP_READ && count_q != '0) begin
			rd_en   = 1'b1;
			count_d = count_q - AW'(1);
		end
		rd_idx = slot_q - count_d;
		if (slot_q < count_d) begin
			rd_idx = slot_q - count_d + DEPTH_MOD;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem[slot_d] <= evt.data;
		end
		if (accept && rd_en) begin
			rdata_s1 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				slot_q  <= slot_d;
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_valid_s1 <= rd_en;
			done_s1       <= (op_in == OP_FALL) && evt.done;
			error_s1      <= (op_in == OP_FALL) && evt.error;
			sync_lost_s1  <= (op_in == OP_FALL) && evt.sync_lost;
			failure_s1    <= evt.failure;
			level_s1      <= 4'(count_d);
		end
	end

	assign out_valid    = out_valid_q;
	assign read_valid   = read_valid_s1;
	assign read_byte    = read_valid_s1 ? rdata_s1 : 8'h00;
	assign frame_done   = done_s1;
	assign frame_error  = error_s1;
	assign sync_lost    = sync_lost_s1;
	assign failure_seen = failure_s1;
	assign unread_level = level_s1;

endmodule

`default_nettype wire

### design/ps2kfr_frame_rx.sv
// Bit sequencer for one PS/2 frame: bit position, shift register, gap timer and sticky failure.
// Depends on ps2kfr_pkg for the op codes, frame positions and the event struct.
`default_nettype none

module ps2kfr_frame_rx (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire ps2kfr_pkg::op_t        op,
	input  wire logic                   data_bit,
	input  wire logic                   cfg_we,
	input  wire logic [7:0]             cfg_data,
	output ps2kfr_pkg::frame_evt_t      evt
);
	import ps2kfr_pkg::*;

	logic [3:0] pos_q, pos_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] gap_q, gap_d;
	logic [7:0] timeout_q;
	logic       fail_q, fail_d;
	logic       restart;
	logic [3:0] pos_eff;

	always_comb begin
		pos_d   = pos_q;
		shift_d = shift_q;
		gap_d   = gap_q;
		fail_d  = fail_q;
		evt     = '0;
		restart = (pos_q != POS_IDLE) && (gap_q > timeout_q);
		pos_eff = restart ? POS_IDLE : pos_q;
		unique case (op)
			OP_FALL: begin
				if (restart) begin
					shift_d = '0;
				end
				if (pos_eff == POS_IDLE) begin
					if (!data_bit) begin
						pos_d   = 4'd1;
						shift_d = '0;
					end else begin
						pos_d         = POS_IDLE;
						evt.sync_lost = 1'b1;
					end
				end else if (pos_eff < POS_PARITY) begin
					shift_d = (shift_q >> 1) | (data_bit ? DATA_MSB : 8'h00);
					pos_d   = pos_eff + 4'd1;
				end else if (pos_eff == POS_PARITY) begin
					pos_d = POS_STOP;
				end else begin
					if (!data_bit) begin
						evt.error = 1'b1;
						fail_d    = 1'b1;
					end else begin
						evt.done = 1'b1;
					end
					pos_d = POS_IDLE;
				end
				gap_d = '0;
			end
			OP_RISE: begin
				gap_d = '0;
			end
			OP_TICK: begin
				if (gap_q != GAP_MAX) begin
					gap_d = gap_q + 8'd1;
				end
			end
			OP_READ: begin
			end
			default: begin
			end
		endcase
		evt.data    = shift_q;
		evt.failure = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_IDLE;
			shift_q   <= '0;
			gap_q     <= '0;
			fail_q    <= 1'b0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			if (step) begin
				pos_q   <= pos_d;
				shift_q <= shift_d;
				gap_q   <= gap_d;
				fail_q  <= fail_d;
			end
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
		end
	end

endmodule

`default_nettype wire
